>>> rtl/core/sha1_pkg.sv
// shared types, constants and round functions for the sha-1 stream hasher
package sha1_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0]  byte_t;

  localparam int unsigned NUM_WORDS   = 5;
  localparam int unsigned ROUNDS      = 80;
  localparam int unsigned BLOCK_BYTES = 64;

  localparam int unsigned ROUND_W = $clog2(ROUNDS);
  localparam int unsigned IDX_W   = $clog2(NUM_WORDS);
  localparam int unsigned POS_W   = $clog2(BLOCK_BYTES);

  localparam logic [ROUND_W-1:0] LAST_ROUND   = ROUND_W'(ROUNDS - 1);
  localparam logic [IDX_W-1:0]   LAST_IDX     = IDX_W'(NUM_WORDS - 1);
  localparam logic [POS_W-1:0]   LAST_POS     = POS_W'(BLOCK_BYTES - 1);
  // length field starts where the bit count is 448 mod 512
  localparam logic [POS_W-1:0]   PAD_END_POS  = POS_W'(448 / 8);

  localparam logic  CMD_APPEND = 1'b0;
  localparam logic  CMD_FINISH = 1'b1;
  localparam byte_t PAD_MARK   = 8'h80;

  localparam word_t K_0 = 32'h5A827999;
  localparam word_t K_1 = 32'h6ED9EBA1;
  localparam word_t K_2 = 32'h8F1BBCDC;
  localparam word_t K_3 = 32'hCA62C1D6;

  localparam word_t H_INIT [NUM_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  function automatic word_t sha1_f(logic [ROUND_W-1:0] rnd, word_t b, word_t c, word_t d);
    word_t f;
    if (rnd < ROUND_W'(20)) begin
      f = (b & c) | (~b & d);
    end else if (rnd < ROUND_W'(40)) begin
      f = b ^ c ^ d;
    end else if (rnd < ROUND_W'(60)) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

  function automatic word_t sha1_k(logic [ROUND_W-1:0] rnd);
    word_t k;
    if (rnd < ROUND_W'(20)) begin
      k = K_0;
    end else if (rnd < ROUND_W'(40)) begin
      k = K_1;
    end else if (rnd < ROUND_W'(60)) begin
      k = K_2;
    end else begin
      k = K_3;
    end
    return k;
  endfunction

endpackage

>>> rtl/core/sha1_if.sv
// request and digest channel interfaces of the sha-1 stream hasher
interface sha1_in_if;
  logic                valid;
  logic                ready;
  logic                command;
  sha1_pkg::byte_t     message_byte;

  modport source (output valid, output command, output message_byte, input ready);
  modport sink   (input valid, input command, input message_byte, output ready);
endinterface

interface sha1_out_if;
  logic                           valid;
  logic                           ready;
  sha1_pkg::word_t                digest_word;
  logic [sha1_pkg::IDX_W-1:0]     word_index;
  logic                           last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink   (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface

>>> rtl/core/sha1_stream_hasher.sv
// sha-1 stream hasher: byte buffer, shared round unit and padding sequencer
// an append request pushes one byte; one that completes a 64-byte block starts
// a compression (80 rounds through the single round unit, then the chaining add)
// a finish request pushes 9 to 72 padding bytes, one per cycle outside compressions,
// runs 1 or 2 more compressions, then offers 5 digest words, one per cycle if ready
// reset (synchronous, rst_n low) loads the initial chaining words and clears the bit
// count; the block buffer is not cleared
module sha1_stream_hasher (
  input  logic             clk,
  input  logic             rst_n,
  sha1_in_if.sink          in_chan,
  sha1_out_if.source       out_chan
);

  typedef enum logic [2:0] {ST_IDLE, ST_ROUND, ST_ADD, ST_PAD, ST_EMIT} state_t;
  typedef enum logic [1:0] {PK_MARK, PK_ZERO, PK_LEN, PK_DONE} pad_kind_t;

  localparam int unsigned BUF_W = sha1_pkg::BLOCK_BYTES * 8;

  state_t                           state_r, state_nxt;
  pad_kind_t                        pad_kind_r, pad_kind_nxt;
  logic [sha1_pkg::ROUND_W-1:0]     round_r, round_nxt;
  logic [BUF_W-1:0]                 buf_r, buf_nxt;
  logic [63:0]                      bit_count_r, bit_count_nxt;
  logic [63:0]                      len_r, len_nxt;
  logic [2:0]                       len_cnt_r, len_cnt_nxt;
  logic                             finishing_r, finishing_nxt;
  logic [sha1_pkg::IDX_W-1:0]       emit_idx_r, emit_idx_nxt;
  sha1_pkg::word_t                  chain_r [sha1_pkg::NUM_WORDS];
  sha1_pkg::word_t                  chain_nxt [sha1_pkg::NUM_WORDS];
  sha1_pkg::word_t                  a_r, b_r, c_r, d_r, e_r;
  sha1_pkg::word_t                  a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;

  logic                             in_fire, out_fire;
  logic                             push_en;
  sha1_pkg::byte_t                  push_byte;
  logic [sha1_pkg::POS_W-1:0]       pos;
  sha1_pkg::word_t                  w_cur, w_mix, w_new, t_sum;

  assign in_chan.ready        = (state_r == ST_IDLE);
  assign out_chan.valid       = (state_r == ST_EMIT);
  assign out_chan.digest_word = chain_r[emit_idx_r];
  assign out_chan.word_index  = emit_idx_r;
  assign out_chan.last_word   = (emit_idx_r == sha1_pkg::LAST_IDX);

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_fire = out_chan.valid && out_chan.ready;
  assign pos      = bit_count_r[3 +: sha1_pkg::POS_W];

  // the buffer doubles as the 16-word schedule window, oldest word on top
  assign w_cur = buf_r[BUF_W-1 -: 32];
  assign w_mix = buf_r[BUF_W-1 -: 32] ^ buf_r[BUF_W-1-64 -: 32] ^
                 buf_r[BUF_W-1-256 -: 32] ^ buf_r[BUF_W-1-416 -: 32];
  assign w_new = {w_mix[30:0], w_mix[31]};
  assign t_sum = {a_r[26:0], a_r[31:27]} + sha1_pkg::sha1_f(round_r, b_r, c_r, d_r) + e_r +
                 sha1_pkg::sha1_k(round_r) + w_cur;

  always_comb begin
    state_nxt     = state_r;
    pad_kind_nxt  = pad_kind_r;
    round_nxt     = round_r;
    buf_nxt       = buf_r;
    bit_count_nxt = bit_count_r;
    len_nxt       = len_r;
    len_cnt_nxt   = len_cnt_r;
    finishing_nxt = finishing_r;
    emit_idx_nxt  = emit_idx_r;
    chain_nxt     = chain_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    c_nxt         = c_r;
    d_nxt         = d_r;
    e_nxt         = e_r;
    push_en       = 1'b0;
    push_byte     = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_chan.command == sha1_pkg::CMD_FINISH) begin
            finishing_nxt = 1'b1;
            len_nxt       = bit_count_r;
            len_cnt_nxt   = '0;
            pad_kind_nxt  = PK_MARK;
            state_nxt     = ST_PAD;
          end else begin
            push_en   = 1'b1;
            push_byte = in_chan.message_byte;
          end
        end
      end
      ST_PAD: begin
        unique case (pad_kind_r)
          PK_MARK: begin
            push_en      = 1'b1;
            push_byte    = sha1_pkg::PAD_MARK;
            pad_kind_nxt = PK_ZERO;
          end
          PK_ZERO: begin
            push_en = 1'b1;
            if (pos != sha1_pkg::PAD_END_POS) begin
              push_byte = '0;
            end else begin
              push_byte    = len_r[63:56];
              len_nxt      = {len_r[55:0], 8'h00};
              len_cnt_nxt  = len_cnt_r + 3'd1;
              pad_kind_nxt = PK_LEN;
            end
          end
          PK_LEN: begin
            push_en     = 1'b1;
            push_byte   = len_r[63:56];
            len_nxt     = {len_r[55:0], 8'h00};
            len_cnt_nxt = len_cnt_r + 3'd1;
            if (len_cnt_r == 3'd7) begin
              pad_kind_nxt = PK_DONE;
            end
          end
          default: begin
            state_nxt    = ST_EMIT;
            emit_idx_nxt = '0;
          end
        endcase
      end
      ST_ROUND: begin
        a_nxt     = t_sum;
        b_nxt     = a_r;
        c_nxt     = {b_r[1:0], b_r[31:2]};
        d_nxt     = c_r;
        e_nxt     = d_r;
        buf_nxt   = {buf_r[BUF_W-33:0], w_new};
        round_nxt = round_r + 1'b1;
        if (round_r == sha1_pkg::LAST_ROUND) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        chain_nxt[0] = chain_r[0] + a_r;
        chain_nxt[1] = chain_r[1] + b_r;
        chain_nxt[2] = chain_r[2] + c_r;
        chain_nxt[3] = chain_r[3] + d_r;
        chain_nxt[4] = chain_r[4] + e_r;
        if (finishing_r && pad_kind_r == PK_DONE) begin
          state_nxt    = ST_EMIT;
          emit_idx_nxt = '0;
        end else if (finishing_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_fire) begin
          if (emit_idx_r == sha1_pkg::LAST_IDX) begin
            chain_nxt     = sha1_pkg::H_INIT;
            bit_count_nxt = '0;
            finishing_nxt = 1'b0;
            state_nxt     = ST_IDLE;
          end else begin
            emit_idx_nxt = emit_idx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // shared byte push path, a full buffer starts the round sequence
    if (push_en) begin
      buf_nxt       = {buf_r[BUF_W-9:0], push_byte};
      bit_count_nxt = bit_count_r + 64'd8;
      if (pos == sha1_pkg::LAST_POS) begin
        state_nxt = ST_ROUND;
        round_nxt = '0;
        a_nxt     = chain_r[0];
        b_nxt     = chain_r[1];
        c_nxt     = chain_r[2];
        d_nxt     = chain_r[3];
        e_nxt     = chain_r[4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pad_kind_r  <= PK_MARK;
      round_r     <= '0;
      bit_count_r <= '0;
      len_cnt_r   <= '0;
      finishing_r <= 1'b0;
      emit_idx_r  <= '0;
      chain_r     <= sha1_pkg::H_INIT;
    end else begin
      state_r     <= state_nxt;
      pad_kind_r  <= pad_kind_nxt;
      round_r     <= round_nxt;
      bit_count_r <= bit_count_nxt;
      len_cnt_r   <= len_cnt_nxt;
      finishing_r <= finishing_nxt;
      emit_idx_r  <= emit_idx_nxt;
      chain_r     <= chain_nxt;
    end
    buf_r <= buf_nxt;
    len_r <= len_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    c_r   <= c_nxt;
    d_r   <= d_nxt;
    e_r   <= e_nxt;
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_chan.ready && out_chan.valid))
    else $error("request accepted while digest is being offered");

  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) |-> (round_r <= sha1_pkg::LAST_ROUND))
    else $error("round counter out of range");

  a_full_block_compresses: assert property (@(posedge clk) disable iff (!rst_n)
    (push_en && pos == sha1_pkg::LAST_POS) |=> (state_r == ST_ROUND && round_r == '0))
    else $error("full block did not start compression");

  a_digest_only_when_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == ST_EMIT) |-> (finishing_r && pad_kind_r == PK_DONE && pos == '0))
    else $error("digest offered before padding completed");

  a_reinit_after_digest: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_chan.last_word) |=>
      (state_r == ST_IDLE && bit_count_r == '0 && !finishing_r))
    else $error("hasher not reinitialized after final digest word");

endmodule
